@@ rtl/core/iat_pkg.sv @@
// shared types, codes and constants of the interrupt action table
package iat_pkg;

  localparam int DATA_W          = 32;
  localparam int ACT_W           = 2;
  localparam int IDX_W           = 4;
  localparam int CNT_OUT_W       = 5;
  localparam int TABLE_DEPTH_DEF = 16;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 2'd0,
    ACT_FIND   = 2'd1,
    ACT_REMOVE = 2'd2
  } iat_act_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } iat_status_e;

  typedef struct packed {
    logic [DATA_W-1:0] handler;
    logic [DATA_W-1:0] policy;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] device;
  } iat_entry_t;

  // controller to datapath
  typedef struct packed {
    logic        load;
    logic        append;
    logic        dec_cnt;
    logic        ptr_zero;
    logic        ptr_idx;
    logic        scan;
    logic        shift;
    logic        set_res;
    iat_status_e res_code;
    logic        res_hit;
    logic        out_load;
  } iat_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             full;
    logic             empty;
    logic             idx_oob;
    logic             idx_last;
    logic             chk_vld;
    logic             match;
    logic             chk_last;
    logic             out_free;
  } iat_stat_t;

endpackage

@@ rtl/core/irq_action_table_top.sv @@
// top level of the interrupt action table: controller plus datapath
//
// The input channel (in_valid_i / in_ready_o) takes one command item: append
// an entry, find the first entry matching device and handler id (either
// comparison may be a wildcard), or remove the entry at a position. The
// output channel (out_valid_o / out_ready_i) returns exactly one result item
// per command: a status code, the matching entry on a find hit, and the
// number of entries held afterwards.
// Append, rejected commands and removal of the last entry go straight from
// decode to the result register. A find scans from position 0 up to the hit
// (or the last entry on a miss), reading one entry per cycle through the
// registered memory port. A remove at index i moves every entry behind i one
// place toward the head, one entry per cycle. One command is in work at a
// time and the next is taken the cycle after the result is loaded.
// A result waits in the output register while the receiver stalls; the
// next command is still accepted and worked, its result held until that register frees up.
// Reset empties the table (entry count zero); stored entries are not
// cleared, and only positions below the count are ever read.
module irq_action_table_top #(
  parameter int TABLE_DEPTH = iat_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [iat_pkg::ACT_W-1:0]     action_i,
  input  logic [iat_pkg::DATA_W-1:0]    handler_id_i,
  input  logic [iat_pkg::DATA_W-1:0]    policy_bits_i,
  input  logic [iat_pkg::DATA_W-1:0]    mask_bits_i,
  input  logic [iat_pkg::DATA_W-1:0]    device_id_i,
  input  logic                          any_device_i,
  input  logic                          any_handler_i,
  input  logic [iat_pkg::IDX_W-1:0]     entry_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [iat_pkg::IDX_W-1:0]     found_index_o,
  output logic [iat_pkg::DATA_W-1:0]    out_handler_o,
  output logic [iat_pkg::DATA_W-1:0]    out_policy_o,
  output logic [iat_pkg::DATA_W-1:0]    out_mask_o,
  output logic [iat_pkg::DATA_W-1:0]    out_device_o,
  output logic [iat_pkg::CNT_OUT_W-1:0] entry_count_o
);
  import iat_pkg::*;

  iat_cmd_t  cmd;
  iat_stat_t stat;

  iat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  iat_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .action_i      (action_i),
    .handler_id_i  (handler_id_i),
    .policy_bits_i (policy_bits_i),
    .mask_bits_i   (mask_bits_i),
    .device_id_i   (device_id_i),
    .any_device_i  (any_device_i),
    .any_handler_i (any_handler_i),
    .entry_index_i (entry_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .found_index_o (found_index_o),
    .out_handler_o (out_handler_o),
    .out_policy_o  (out_policy_o),
    .out_mask_o    (out_mask_o),
    .out_device_o  (out_device_o),
    .entry_count_o (entry_count_o)
  );

endmodule

@@ rtl/core/iat_ctrl.sv @@
// sequencing state machine of the interrupt action table
module iat_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  iat_pkg::iat_stat_t stat_i,
  output iat_pkg::iat_cmd_t  cmd_o
);
  import iat_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_FIND   = 5'b00100,
    S_SHIFT  = 5'b01000,
    S_RESULT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_code = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat_i.act)
          ACT_APPEND: begin
            cmd_o.set_res = 1'b1;
            state_d       = S_RESULT;
            if (stat_i.full) begin
              cmd_o.res_code = ST_FULL;
            end else begin
              cmd_o.append = 1'b1;
            end
          end
          ACT_FIND: begin
            if (stat_i.empty) begin
              cmd_o.set_res  = 1'b1;
              cmd_o.res_code = ST_MISS;
              state_d        = S_RESULT;
            end else begin
              cmd_o.ptr_zero = 1'b1;
              state_d        = S_FIND;
            end
          end
          ACT_REMOVE: begin
            if (stat_i.idx_oob) begin
              cmd_o.set_res  = 1'b1;
              cmd_o.res_code = ST_MISS;
              state_d        = S_RESULT;
            end else if (stat_i.idx_last) begin
              // last entry goes, nothing to move
              cmd_o.dec_cnt = 1'b1;
              cmd_o.set_res = 1'b1;
              state_d       = S_RESULT;
            end else begin
              cmd_o.ptr_idx = 1'b1;
              state_d       = S_SHIFT;
            end
          end
          default: begin
            cmd_o.set_res  = 1'b1;
            cmd_o.res_code = ST_MISS;
            state_d        = S_RESULT;
          end
        endcase
      end
      S_FIND: begin
        cmd_o.scan = 1'b1;
        if (stat_i.chk_vld && stat_i.match) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_hit = 1'b1;
          state_d       = S_RESULT;
        end else if (stat_i.chk_vld && stat_i.chk_last) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = ST_MISS;
          state_d        = S_RESULT;
        end
      end
      S_SHIFT: begin
        cmd_o.scan  = 1'b1;
        cmd_o.shift = 1'b1;
        if (stat_i.chk_vld && stat_i.chk_last) begin
          cmd_o.dec_cnt = 1'b1;
          cmd_o.set_res = 1'b1;
          state_d       = S_RESULT;
        end
      end
      S_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/iat_datapath.sv @@
// entry memory, count, scan pointer and result registers of the action table
module iat_datapath #(
  parameter int TABLE_DEPTH = iat_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  iat_pkg::iat_cmd_t                cmd_i,
  output iat_pkg::iat_stat_t               stat_o,
  input  logic [iat_pkg::ACT_W-1:0]        action_i,
  input  logic [iat_pkg::DATA_W-1:0]       handler_id_i,
  input  logic [iat_pkg::DATA_W-1:0]       policy_bits_i,
  input  logic [iat_pkg::DATA_W-1:0]       mask_bits_i,
  input  logic [iat_pkg::DATA_W-1:0]       device_id_i,
  input  logic                             any_device_i,
  input  logic                             any_handler_i,
  input  logic [iat_pkg::IDX_W-1:0]        entry_index_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       status_o,
  output logic [iat_pkg::IDX_W-1:0]        found_index_o,
  output logic [iat_pkg::DATA_W-1:0]       out_handler_o,
  output logic [iat_pkg::DATA_W-1:0]       out_policy_o,
  output logic [iat_pkg::DATA_W-1:0]       out_mask_o,
  output logic [iat_pkg::DATA_W-1:0]       out_device_o,
  output logic [iat_pkg::CNT_OUT_W-1:0]    entry_count_o
);
  import iat_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  // latched item
  logic [ACT_W-1:0] act_q;
  iat_entry_t       new_q;
  logic             any_dev_q;
  logic             any_hnd_q;
  logic [IDX_W-1:0] idx_q;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic          chk_vld_q;
  logic [AW-1:0] chk_idx_q;

  iat_entry_t    mem_q [TABLE_DEPTH];
  iat_entry_t    rdata_q;

  iat_status_e   res_status_q;
  logic [AW-1:0] res_idx_q;
  iat_entry_t    res_entry_q;

  logic                 out_valid_q;
  logic [1:0]           out_status_q;
  logic [IDX_W-1:0]     out_idx_q;
  iat_entry_t           out_entry_q;
  logic [CNT_OUT_W-1:0] out_cnt_q;

  logic [IW-1:0] idx_ext;
  logic [IW-1:0] cnt_ext;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          match;

  assign idx_ext = IW'(idx_q);
  assign cnt_ext = IW'(count_q);
  assign rd_en   = cmd_i.scan && (ptr_q < count_q);
  assign rd_addr = ptr_q[AW-1:0];
  assign match   = (any_dev_q || (rdata_q.device == new_q.device)) &&
                   (any_hnd_q || (rdata_q.handler == new_q.handler));

  always_comb begin
    stat_o          = '0;
    stat_o.act      = act_q;
    stat_o.full     = (count_q == DepthC);
    stat_o.empty    = (count_q == '0);
    stat_o.idx_oob  = (idx_ext >= cnt_ext);
    stat_o.idx_last = ((idx_ext + IW'(1)) == cnt_ext);
    stat_o.chk_vld  = chk_vld_q;
    stat_o.match    = match;
    stat_o.chk_last = ((CW'(chk_idx_q) + CW'(1)) == count_q);
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.append) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.dec_cnt) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ptr_zero) begin
      ptr_d = '0;
    end else if (cmd_i.ptr_idx) begin
      ptr_d = CW'(idx_ext) + CW'(1);
    end else if (rd_en) begin
      ptr_d = ptr_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      chk_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      ptr_q     <= ptr_d;
      chk_vld_q <= rd_en;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // entry memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      mem_q[count_q[AW-1:0]] <= new_q;
    end else if (cmd_i.shift && chk_vld_q) begin
      // move the entry just read one place toward the head
      mem_q[chk_idx_q - AW'(1)] <= rdata_q;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q          <= action_i;
      new_q.handler  <= handler_id_i;
      new_q.policy   <= policy_bits_i;
      new_q.mask     <= mask_bits_i;
      new_q.device   <= device_id_i;
      any_dev_q      <= any_device_i;
      any_hnd_q      <= any_handler_i;
      idx_q          <= entry_index_i;
    end
    if (rd_en) begin
      chk_idx_q <= rd_addr;
    end
    if (cmd_i.set_res) begin
      res_status_q <= cmd_i.res_code;
      if (cmd_i.res_hit) begin
        res_idx_q   <= chk_idx_q;
        res_entry_q <= rdata_q;
      end else begin
        res_idx_q   <= '0;
        res_entry_q <= '0;
      end
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_idx_q    <= IDX_W'(res_idx_q);
      out_entry_q  <= res_entry_q;
      out_cnt_q    <= CNT_OUT_W'(count_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_index_o = out_idx_q;
  assign out_handler_o = out_entry_q.handler;
  assign out_policy_o  = out_entry_q.policy;
  assign out_mask_o    = out_entry_q.mask;
  assign out_device_o  = out_entry_q.device;
  assign entry_count_o = out_cnt_q;

endmodule

@@ verif/tb_irq_action_table_top.sv @@
// testbench for irq_action_table_top: directed table then random commands vs a shadow table
module tb_irq_action_table_top;
  import iat_pkg::*;

  localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;  // unused action code
  localparam int RAND_ITEMS = 1500;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_PCT = 37;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [DATA_W-1:0] handler;
    logic [DATA_W-1:0] policy;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] device;
    logic              any_dev;
    logic              any_hnd;
    logic [IDX_W-1:0]  idx;
  } table_cmd_t;

  typedef struct packed {
    iat_status_e          status;
    logic [IDX_W-1:0]     idx;
    logic [DATA_W-1:0]    handler;
    logic [DATA_W-1:0]    policy;
    logic [DATA_W-1:0]    mask;
    logic [DATA_W-1:0]    device;
    logic [CNT_OUT_W-1:0] cnt;
  } table_res_t;

  // directed row: reps > 1 repeats the item with handler and device stepped by one
  typedef struct packed {
    logic [ACT_W-1:0]     act;
    logic [DATA_W-1:0]    handler;
    logic [DATA_W-1:0]    policy;
    logic [DATA_W-1:0]    mask;
    logic [DATA_W-1:0]    device;
    logic                 any_dev;
    logic                 any_hnd;
    logic [IDX_W-1:0]     idx;
    logic [4:0]           reps;
    logic                 fixed;
    iat_status_e          st;
    logic [CNT_OUT_W-1:0] cnt;
  } dir_row_t;

  localparam int DIR_ROWS = 21;

  dir_row_t dir_tab [DIR_ROWS] = '{
    // empty table
    '{ACT_FIND,   '0, '0, '0, '0, 1'b1, 1'b1, 4'd0, 5'd1, 1'b1, ST_MISS, 5'd0},
    '{ACT_REMOVE, '0, '0, '0, '0, 1'b0, 1'b0, 4'd0, 5'd1, 1'b1, ST_MISS, 5'd0},
    '{ACT_NONE,   '0, '0, '0, '0, 1'b0, 1'b0, 4'd0, 5'd1, 1'b1, ST_MISS, 5'd0},
    '{ACT_APPEND, '1, '0, '1, '0, 1'b0, 1'b0, 4'd0, 5'd1, 1'b1, ST_OK,   5'd1},
    '{ACT_APPEND, '0, '1, '0, '1, 1'b0, 1'b0, 4'd0, 5'd1, 1'b1, ST_OK,   5'd2},
    // hits and wildcards
    '{ACT_FIND,   '0, '0, '0, '0, 1'b1, 1'b1, 4'd0, 5'd1, 1'b0, ST_OK,   5'd0},
    '{ACT_FIND,   '0, '0, '0, '1, 1'b0, 1'b0, 4'd0, 5'd1, 1'b0, ST_OK,   5'd0},
    '{ACT_FIND,   '0, '0, '0, '0, 1'b1, 1'b0, 4'd0, 5'd1, 1'b0, ST_OK,   5'd0},
    '{ACT_FIND,   '1, '0, '0, '0, 1'b0, 1'b1, 4'd0, 5'd1, 1'b0, ST_OK,   5'd0},
    '{ACT_FIND,   '1, '0, '0, '1, 1'b0, 1'b0, 4'd0, 5'd1, 1'b1, ST_MISS, 5'd2},
    // fill up, then overflow
    '{ACT_APPEND, 32'h1000_0000, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h2000_0000,
      1'b0, 1'b0, 4'd0, 5'd14, 1'b0, ST_OK, 5'd0},
    '{ACT_APPEND, '1, '1, '1, '1, 1'b0, 1'b0, 4'd0, 5'd1, 1'b1, ST_FULL, 5'd16},
    '{ACT_FIND,   32'h1000_000D, '0, '0, 32'h2000_000D,
      1'b0, 1'b0, 4'd0, 5'd1, 1'b0, ST_OK, 5'd0},
    '{ACT_FIND,   32'h1000_0000, '0, '0, '0, 1'b1, 1'b0, 4'd0, 5'd1, 1'b0, ST_OK, 5'd0},
    // removal at the ends and out of range
    '{ACT_REMOVE, '0, '0, '0, '0, 1'b0, 1'b0, 4'd15, 5'd1, 1'b1, ST_OK,   5'd15},
    '{ACT_REMOVE, '0, '0, '0, '0, 1'b0, 1'b0, 4'd15, 5'd1, 1'b1, ST_MISS, 5'd15},
    '{ACT_REMOVE, '0, '0, '0, '0, 1'b0, 1'b0, 4'd0,  5'd1, 1'b1, ST_OK,   5'd14},
    '{ACT_FIND,   '0, '0, '0, '0, 1'b1, 1'b1, 4'd0,  5'd1, 1'b0, ST_OK,   5'd0},
    '{ACT_NONE,   '1, '1, '1, '1, 1'b1, 1'b1, 4'd15, 5'd1, 1'b1, ST_MISS, 5'd14},
    '{ACT_REMOVE, '0, '0, '0, '0, 1'b0, 1'b0, 4'd5,  5'd1, 1'b0, ST_OK,   5'd0},
    '{ACT_FIND,   32'h1000_0005, '0, '0, 32'h2000_0005,
      1'b0, 1'b0, 4'd0, 5'd1, 1'b0, ST_OK, 5'd0}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [ACT_W-1:0]     action_i = '0;
  logic [DATA_W-1:0]    handler_id_i = '0;
  logic [DATA_W-1:0]    policy_bits_i = '0;
  logic [DATA_W-1:0]    mask_bits_i = '0;
  logic [DATA_W-1:0]    device_id_i = '0;
  logic                 any_device_i = 1'b0;
  logic                 any_handler_i = 1'b0;
  logic [IDX_W-1:0]     entry_index_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [1:0]           status_o;
  logic [IDX_W-1:0]     found_index_o;
  logic [DATA_W-1:0]    out_handler_o;
  logic [DATA_W-1:0]    out_policy_o;
  logic [DATA_W-1:0]    out_mask_o;
  logic [DATA_W-1:0]    out_device_o;
  logic [CNT_OUT_W-1:0] entry_count_o;

  // shadow copy of the table
  iat_entry_t shadow_tab [TABLE_DEPTH];
  int         shadow_cnt = 0;
  table_res_t table_answers_q [$];

  int  fails = 0;
  int  stall_cycles = 0;
  bit  no_idle = 1'b0;
  int  n_cmds = 0, n_appends = 0, n_full = 0, n_finds = 0, n_hits = 0;
  int  n_removes = 0, n_ignored = 0, n_unused = 0, peak_cnt = 0;

  irq_action_table_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .handler_id_i (handler_id_i),
    .policy_bits_i(policy_bits_i),
    .mask_bits_i  (mask_bits_i),
    .device_id_i  (device_id_i),
    .any_device_i (any_device_i),
    .any_handler_i(any_handler_i),
    .entry_index_i(entry_index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .found_index_o(found_index_o),
    .out_handler_o(out_handler_o),
    .out_policy_o (out_policy_o),
    .out_mask_o   (out_mask_o),
    .out_device_o (out_device_o),
    .entry_count_o(entry_count_o)
  );

  always #4 clk_i = ~clk_i;

  // applies one command to the shadow table and returns what the block should answer
  function automatic table_res_t table_apply(table_cmd_t c);
    table_res_t r;
    bit         hit;
    r = '0;
    r.status = ST_MISS;
    hit = 1'b0;
    n_cmds++;
    case (c.act)
      ACT_APPEND: begin
        n_appends++;
        if (shadow_cnt >= TABLE_DEPTH) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          shadow_tab[shadow_cnt] = '{c.handler, c.policy, c.mask, c.device};
          shadow_cnt++;
          r.status = ST_OK;
        end
      end
      ACT_FIND: begin
        n_finds++;
        for (int p = 0; p < shadow_cnt; p++) begin
          if (!hit && (c.any_dev || shadow_tab[p].device == c.device) &&
              (c.any_hnd || shadow_tab[p].handler == c.handler)) begin
            hit = 1'b1;
            r.status = ST_OK;
            r.idx = IDX_W'(p);
            r.handler = shadow_tab[p].handler;
            r.policy = shadow_tab[p].policy;
            r.mask = shadow_tab[p].mask;
            r.device = shadow_tab[p].device;
          end
        end
        if (hit) n_hits++;
      end
      ACT_REMOVE: begin
        n_removes++;
        if (int'(c.idx) < shadow_cnt) begin
          for (int p = int'(c.idx); p < shadow_cnt - 1; p++) shadow_tab[p] = shadow_tab[p + 1];
          shadow_cnt--;
          r.status = ST_OK;
        end else begin
          n_ignored++;
        end
      end
      default: n_unused++;
    endcase
    if (shadow_cnt > peak_cnt) peak_cnt = shadow_cnt;
    r.cnt = CNT_OUT_W'(shadow_cnt);
    return r;
  endfunction

  function automatic int idle_gap();
    int gap;
    gap = 0;
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) gap++;
    end
    return gap;
  endfunction

  // ids from a small pool so that duplicates and repeated matches are common
  function automatic logic [DATA_W-1:0] pick_id();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3, 4: return DATA_W'($urandom_range(5));
      default: return $urandom;
    endcase
  endfunction

  // call it just after the clock rises; returns once the block has accepted the item
  task automatic send_cmd(input table_cmd_t c, input bit use_typed, input table_res_t typed);
    int         gap;
    table_res_t r;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= c.act;
    handler_id_i  <= c.handler;
    policy_bits_i <= c.policy;
    mask_bits_i   <= c.mask;
    device_id_i   <= c.device;
    any_device_i  <= c.any_dev;
    any_handler_i <= c.any_hnd;
    entry_index_i <= c.idx;
    do @(posedge clk_i); while (!in_ready_o);
    r = table_apply(c);
    table_answers_q.push_back(use_typed ? typed : r);
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  task automatic compare_result();
    table_res_t e;
    if (table_answers_q.size() == 0) begin
      $error("result item with no command pending: status %0d", status_o);
      fails++;
      return;
    end
    e = table_answers_q.pop_front();
    check_field("status", DATA_W'(e.status), DATA_W'(status_o));
    check_field("found_index", DATA_W'(e.idx), DATA_W'(found_index_o));
    check_field("out_handler", e.handler, out_handler_o);
    check_field("out_policy", e.policy, out_policy_o);
    check_field("out_mask", e.mask, out_mask_o);
    check_field("out_device", e.device, out_device_o);
    check_field("entry_count", DATA_W'(e.cnt), DATA_W'(entry_count_o));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) compare_result();
    out_ready_i <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    table_cmd_t c;
    table_res_t typed;
    int         roll;
    int         k;
    bit         fill_phase;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[r]) begin
      for (int n = 0; n < int'(dir_tab[r].reps); n++) begin
        c = '{dir_tab[r].act, dir_tab[r].handler + DATA_W'(n), dir_tab[r].policy,
              dir_tab[r].mask, dir_tab[r].device + DATA_W'(n), dir_tab[r].any_dev,
              dir_tab[r].any_hnd, dir_tab[r].idx};
        typed = '0;
        typed.status = dir_tab[r].st;
        typed.cnt = dir_tab[r].cnt;
        send_cmd(c, dir_tab[r].fixed, typed);
      end
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      no_idle = (n >= 600 && n < 850);
      // alternate between phases that fill the table and phases that drain it
      fill_phase = ((n / 150) % 2) == 0;
      roll = $urandom_range(99);
      c.handler = $urandom;
      c.policy  = $urandom;
      c.mask    = $urandom;
      c.device  = $urandom;
      c.any_dev = 1'($urandom_range(1));
      c.any_hnd = 1'($urandom_range(1));
      c.idx     = IDX_W'($urandom_range(15));
      if (roll < 3) begin
        c.act = ACT_NONE;
      end else if (roll < (fill_phase ? 55 : 30)) begin
        c.act = ACT_APPEND;
        c.handler = pick_id();
        c.device = pick_id();
      end else if (roll < (fill_phase ? 82 : 68)) begin
        c.act = ACT_FIND;
        if (shadow_cnt > 0 && $urandom_range(99) < 65) begin
          k = $urandom_range(shadow_cnt - 1);
          c.handler = shadow_tab[k].handler;
          c.device = shadow_tab[k].device;
          c.any_dev = ($urandom_range(3) == 0);
          c.any_hnd = ($urandom_range(3) == 0);
        end else begin
          c.handler = pick_id();
          c.device = pick_id();
        end
      end else begin
        c.act = ACT_REMOVE;
        if (shadow_cnt > 0 && $urandom_range(99) < 85) c.idx = IDX_W'($urandom_range(shadow_cnt - 1));
      end
      send_cmd(c, 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    no_idle = 1'b0;

    while (table_answers_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d commands: %0d appends (%0d rejected full), %0d finds (%0d hits),",
             n_cmds, n_appends, n_full, n_finds, n_hits);
    $display("%0d removes (%0d out of range), %0d unused codes, up to %0d entries held",
             n_removes, n_ignored, n_unused, peak_cnt);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ irq_action_table_top.f @@
rtl/core/iat_pkg.sv
rtl/core/iat_ctrl.sv
rtl/core/iat_datapath.sv
rtl/core/irq_action_table_top.sv
verif/tb_irq_action_table_top.sv
